// ===== src/websocket_frame_deframer_core_macros.svh =====
// assertion helpers shared by the deframer modules
`ifndef WEBSOCKET_FRAME_DEFRAMER_CORE_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_CORE_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, checked outside reset
`define WSFD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, checked outside reset
`define WSFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define WSFD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg)
`define WSFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== src/wsfd_pkg.sv =====
package wsfd_pkg;

  // result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // frame kinds
  localparam logic [2:0] FK_OTHER = 3'd0;
  localparam logic [2:0] FK_TEXT  = 3'd1;
  localparam logic [2:0] FK_CLOSE = 3'd2;
  localparam logic [2:0] FK_PING  = 3'd3;
  localparam logic [2:0] FK_PONG  = 3'd4;

  // opcodes, low nibble of the first header byte
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  // 7-bit length escapes and header byte counts
  localparam logic [6:0] LEN_EXT16   = 7'd126;
  localparam logic [6:0] LEN_EXT64   = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  // one classified beat between the parser and the output stage
  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] frame_kind;
    logic [7:0] data;
    logic [7:0] key;
    logic       last;
  } item_t;

  function automatic logic [2:0] decode_kind(input logic [7:0] b);
    logic [2:0] fk;
    case (b[3:0])
      OP_TEXT:  fk = FK_TEXT;
      OP_CLOSE: fk = FK_CLOSE;
      OP_PING:  fk = FK_PING;
      OP_PONG:  fk = FK_PONG;
      default:  fk = FK_OTHER;
    endcase
    return fk;
  endfunction

endpackage

// ===== src/wsfd_front.sv =====
`include "websocket_frame_deframer_core_macros.svh"

module wsfd_front import wsfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] rx_byte_i,
  output logic       push_o,
  output item_t      push_item_o
);

  typedef enum logic [4:0] {
    ST_HDR0 = 5'b00001,
    ST_HDR1 = 5'b00010,
    ST_EXT  = 5'b00100,
    ST_MASK = 5'b01000,
    ST_DATA = 5'b10000
  } state_e;

  state_e      state_q, state_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [63:0] left_q, left_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  midx_q, midx_d;
  logic [2:0]  fcode_q, fcode_d;
  logic        masked_q, masked_d;
  logic        halted_q, halted_d;

  logic [3:0]  cnt_dec;
  logic [63:0] left_shift;
  logic [63:0] left_dec;
  logic [6:0]  len7;
  logic [7:0]  key_byte;

  assign cnt_dec    = cnt_q - 4'd1;
  assign left_shift = {left_q[55:0], rx_byte_i};
  assign left_dec   = left_q - 64'd1;
  assign len7       = rx_byte_i[6:0];

  // mask byte for the current payload position, first key byte first
  always_comb begin
    case (midx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
    if (!masked_q) key_byte = 8'd0;
  end

  // header parser and payload counter
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    left_d      = left_q;
    key_d       = key_q;
    midx_d      = midx_q;
    fcode_d     = fcode_q;
    masked_d    = masked_q;
    halted_d    = halted_q;
    push_o      = 1'b0;
    push_item_o = '{kind: KIND_EMPTY, frame_kind: fcode_q, data: 8'd0, key: 8'd0,
                    last: 1'b1};
    if (accept_i && !halted_q) begin
      unique case (state_q)
        ST_HDR1: begin
          masked_d = rx_byte_i[7];
          left_d   = '0;
          if (len7 == LEN_EXT16) begin
            state_d = ST_EXT;
            cnt_d   = EXT16_BYTES;
          end else if (len7 == LEN_EXT64) begin
            state_d = ST_EXT;
            cnt_d   = EXT64_BYTES;
          end else begin
            left_d = 64'(len7);
            key_d  = '0;
            if (rx_byte_i[7]) begin
              state_d = ST_MASK;
              cnt_d   = KEY_BYTES;
            end else begin
              midx_d = 2'd0;
              if (len7 == 7'd0) begin
                state_d = ST_HDR0;
                push_o  = 1'b1;
              end else begin
                state_d = ST_DATA;
              end
            end
          end
        end
        ST_EXT: begin
          left_d = left_shift;
          cnt_d  = cnt_dec;
          if (cnt_dec == 4'd0) begin
            key_d = '0;
            if (masked_q) begin
              state_d = ST_MASK;
              cnt_d   = KEY_BYTES;
            end else begin
              midx_d = 2'd0;
              if (left_shift == 64'd0) begin
                state_d = ST_HDR0;
                push_o  = 1'b1;
              end else begin
                state_d = ST_DATA;
              end
            end
          end
        end
        ST_MASK: begin
          key_d = {key_q[23:0], rx_byte_i};
          cnt_d = cnt_dec;
          if (cnt_dec == 4'd0) begin
            midx_d = 2'd0;
            if (left_q == 64'd0) begin
              state_d = ST_HDR0;
              push_o  = 1'b1;
            end else begin
              state_d = ST_DATA;
            end
          end
        end
        ST_DATA: begin
          midx_d      = midx_q + 2'd1;
          left_d      = left_dec;
          push_o      = 1'b1;
          push_item_o = '{kind: KIND_DATA, frame_kind: fcode_q, data: rx_byte_i,
                          key: key_byte, last: (left_dec == 64'd0)};
          if (left_dec == 64'd0) state_d = ST_HDR0;
        end
        default: begin
          // first header byte, also the recovery path for a corrupt state
          state_d = ST_HDR0;
          if (!rx_byte_i[7]) begin
            halted_d    = 1'b1;
            push_o      = 1'b1;
            push_item_o = '{kind: KIND_ERROR, frame_kind: decode_kind(rx_byte_i),
                            data: 8'd0, key: 8'd0, last: 1'b1};
          end else begin
            fcode_d = decode_kind(rx_byte_i);
            state_d = ST_HDR1;
            cnt_d   = 4'd0;
          end
        end
      endcase
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_HDR0;
      cnt_q    <= '0;
      left_q   <= '0;
      key_q    <= '0;
      midx_q   <= '0;
      fcode_q  <= '0;
      masked_q <= 1'b0;
      halted_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      left_q   <= left_d;
      key_q    <= key_d;
      midx_q   <= midx_d;
      fcode_q  <= fcode_d;
      masked_q <= masked_d;
      halted_q <= halted_d;
    end
  end

  // an error halts the parser for good and nothing follows it
  `WSFD_ASSERT_NEXT(a_halt_sticky, clk_i, rst_ni, halted_q, halted_q, "halt cleared")
  `WSFD_ASSERT_NOW(a_halt_quiet, clk_i, rst_ni, halted_q, !push_o, "beat after halt")

endmodule

// ===== src/wsfd_queue.sv =====
`include "websocket_frame_deframer_core_macros.svh"

module wsfd_queue import wsfd_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t head_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  item_t         mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_item_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // the parser must never push into a full queue
  `WSFD_ASSERT_NOW(a_no_overflow, clk_i, rst_ni, push_i, !full_o, "push while full")
  `WSFD_ASSERT_NOW(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q <= CW'(DEPTH), "count overrun")

endmodule

// ===== src/wsfd_back.sv =====
`include "websocket_frame_deframer_core_macros.svh"

module wsfd_back import wsfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  item_t      item_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [2:0] frame_kind_o,
  output logic [7:0] payload_byte_o,
  output logic       last_o
);

  logic       valid_q;
  logic [1:0] kind_q;
  logic [2:0] fk_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       take;

  // output register is free when empty or being taken this cycle
  assign take  = !valid_q || !out_stall_i;
  assign pop_o = valid_i && take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= valid_i;
    end
  end

  // unmask and load the result beat
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q <= item_i.kind;
      fk_q   <= item_i.frame_kind;
      byte_q <= item_i.data ^ item_i.key;
      last_q <= item_i.last;
    end
  end

  assign out_valid_o    = valid_q;
  assign kind_o         = kind_q;
  assign frame_kind_o   = fk_q;
  assign payload_byte_o = byte_q;
  assign last_o         = last_q;

  `WSFD_ASSERT_NEXT(a_pop_shows, clk_i, rst_ni, pop_o, valid_q, "popped beat lost")

endmodule

// ===== src/websocket_frame_deframer_core.sv =====
// WebSocket frame deframer.
// Input channel: one received byte per beat on rx_byte_i, accepted at a rising
// edge with in_valid_i high and in_stall_o low. The parser decodes FIN, opcode,
// mask bit, 7/16/64-bit payload length and the 4-byte mask key.
// Output channel: one result beat (kind_o, frame_kind_o, payload_byte_o, last_o),
// taken at an edge with out_valid_o high and out_stall_i low. Payload bytes come
// out unmasked; an empty frame gives one end beat; a first header byte without
// FIN gives an error beat, after which all input is swallowed until reset.
// Header bytes give no beat otherwise.
// The accepting edge writes the byte's beat into the queue; the output register
// loads it from the queue head once that register is empty or being taken.
// Throughput: one byte per clock while in_stall_o stays low, one parser step per byte.
// A two-entry queue sits between parser and output register; when the receiver
// stalls, the queue fills and in_stall_o rises once it is full.
// Reset (rst_ni low, asynchronous) returns the parser to the first header byte,
// clears the halt and empties the queue and the output register.
module websocket_frame_deframer_core import wsfd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [2:0] frame_kind_o,
  output logic [7:0] payload_byte_o,
  output logic       last_o
);

  logic  q_full, q_valid, q_pop, push;
  item_t push_item, head;

  assign in_stall_o = q_full;

  // parser
  wsfd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_valid_i && !q_full),
    .rx_byte_i   (rx_byte_i),
    .push_o      (push),
    .push_item_o (push_item)
  );

  // decoupling queue
  wsfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (head)
  );

  // unmask and output stage
  wsfd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (q_valid),
    .item_i         (head),
    .pop_o          (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .frame_kind_o   (frame_kind_o),
    .payload_byte_o (payload_byte_o),
    .last_o         (last_o)
  );

endmodule

// ===== bench/websocket_frame_deframer_core_test.sv =====
`timescale 1ns / 100ps

module websocket_frame_deframer_core_test import wsfd_pkg::*; ();

  // one result beat as seen on the output channel
  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] frame_kind;
    logic [7:0] payload_byte;
    logic       last;
  } deframe_result_t;

  // where the parser stands within a frame
  typedef enum logic [2:0] {
    P_HDR0, P_HDR1, P_EXT, P_KEY, P_DATA
  } parse_phase_e;

  // how the payload length is encoded in the header
  typedef enum int {
    LEN_SHORT, LEN_WIDE16, LEN_WIDE64
  } len_form_e;

  // deframer predictor and store of expected result beats
  class deframe_scoreboard;
    parse_phase_e    parse_phase;
    logic [3:0]      hdr_left;
    logic [63:0]     remaining;
    logic [31:0]     key;
    logic [1:0]      key_idx;
    logic [2:0]      code;
    logic            masked;
    logic            halted;
    deframe_result_t pending[$];
    int              errors;

    function new();
      parse_phase = P_HDR0;
      hdr_left    = '0;
      remaining   = '0;
      key         = '0;
      key_idx     = '0;
      code        = FK_OTHER;
      masked      = 1'b0;
      halted      = 1'b0;
      errors      = 0;
    endfunction

    function logic [2:0] frame_kind_of(input logic [7:0] b);
      if (b[3:0] == OP_TEXT) return FK_TEXT;
      if (b[3:0] == OP_CLOSE) return FK_CLOSE;
      if (b[3:0] == OP_PING) return FK_PING;
      if (b[3:0] == OP_PONG) return FK_PONG;
      return FK_OTHER;
    endfunction

    // append one expected beat at the tail
    function void queue_beat(input logic [1:0] kind, input logic [2:0] fk,
                             input logic [7:0] pb, input logic last);
      deframe_result_t r;
      r = '{kind, fk, pb, last};
      pending.insert(pending.size(), r);
    endfunction

    // header done: either payload follows or the frame ends empty
    function void header_complete();
      key_idx = '0;
      if (remaining == 0) begin
        parse_phase = P_HDR0;
        queue_beat(KIND_EMPTY, code, 8'h00, 1'b1);
      end else begin
        parse_phase = P_DATA;
      end
    endfunction

    // length known: a masked frame still needs its key
    function void length_known();
      key = '0;
      if (masked) begin
        parse_phase = P_KEY;
        hdr_left    = KEY_BYTES;
      end else begin
        header_complete();
      end
    endfunction

    // one accepted input beat
    function void note_byte(input logic [7:0] b);
      logic [7:0] k;
      if (halted) return;
      case (parse_phase)
        P_HDR1: begin
          masked    = b[7];
          remaining = '0;
          if (b[6:0] == LEN_EXT16) begin
            parse_phase = P_EXT;
            hdr_left    = EXT16_BYTES;
          end else if (b[6:0] == LEN_EXT64) begin
            parse_phase = P_EXT;
            hdr_left    = EXT64_BYTES;
          end else begin
            remaining = {57'd0, b[6:0]};
            length_known();
          end
        end
        P_EXT: begin
          remaining = {remaining[55:0], b};
          hdr_left  = hdr_left - 4'd1;
          if (hdr_left == 0) length_known();
        end
        P_KEY: begin
          key      = {key[23:0], b};
          hdr_left = hdr_left - 4'd1;
          if (hdr_left == 0) header_complete();
        end
        P_DATA: begin
          k         = masked ? key[24 - 8 * int'(key_idx) +: 8] : 8'h00;
          key_idx   = key_idx + 2'd1;
          remaining = remaining - 64'd1;
          queue_beat(KIND_DATA, code, b ^ k, remaining == 0);
          if (remaining == 0) parse_phase = P_HDR0;
        end
        default: begin
          if (!b[7]) begin
            // missing fin halts the parser for good
            halted      = 1'b1;
            parse_phase = P_HDR0;
            queue_beat(KIND_ERROR, frame_kind_of(b), 8'h00, 1'b1);
          end else begin
            code        = frame_kind_of(b);
            parse_phase = P_HDR1;
            hdr_left    = '0;
          end
        end
      endcase
    endfunction

    task report(input string msg);
      $display("%0t mismatch: %s", $time, msg);
      errors++;
    endtask

    // one accepted output beat against the oldest expectation
    task check_result(input logic [1:0] kind, input logic [2:0] fk,
                      input logic [7:0] pb, input logic last);
      deframe_result_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected beat kind %0d byte %02h", kind, pb));
        return;
      end
      want = pending.pop_front();
      if (kind !== want.kind)
        report($sformatf("kind got %0d want %0d", kind, want.kind));
      if (fk !== want.frame_kind)
        report($sformatf("frame_kind got %0d want %0d", fk, want.frame_kind));
      if (pb !== want.payload_byte)
        report($sformatf("payload_byte got %02h want %02h", pb, want.payload_byte));
      if (last !== want.last)
        report($sformatf("last got %0d want %0d", last, want.last));
    endtask
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] rx_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [1:0] kind_o;
  logic [2:0] frame_kind_o;
  logic [7:0] payload_byte_o;
  logic       last_o;

  deframe_scoreboard sb = new();
  int   bytes_sent = 0;
  logic calm = 1'b0;

  websocket_frame_deframer_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .frame_kind_o   (frame_kind_o),
    .payload_byte_o (payload_byte_o),
    .last_o         (last_o)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // result monitor and random receiver stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(kind_o, frame_kind_o, payload_byte_o, last_o);
    out_stall_i <= rst_ni && !calm && ($urandom_range(0, 99) < 10);
  end

  // one input beat, with a random idle gap ahead of it
  task automatic send_byte(input logic [7:0] b);
    if (!calm) begin
      while ($urandom_range(0, 99) < 10) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_byte(b);
    bytes_sent++;
    calm <= (bytes_sent >= 500 && bytes_sent < 800);
  endtask

  // whole frame: header, length, key and random payload
  task automatic send_frame(input logic [7:0] first, input len_form_e form,
                            input logic [63:0] len, input logic is_masked,
                            input logic [31:0] mkey);
    int n_ext;
    send_byte(first);
    case (form)
      LEN_SHORT: begin
        n_ext = 0;
        send_byte({is_masked, len[6:0]});
      end
      LEN_WIDE16: begin
        n_ext = 2;
        send_byte({is_masked, LEN_EXT16});
      end
      default: begin
        n_ext = 8;
        send_byte({is_masked, LEN_EXT64});
      end
    endcase
    for (int i = n_ext - 1; i >= 0; i--) send_byte(len[8 * i +: 8]);
    if (is_masked)
      for (int i = 3; i >= 0; i--) send_byte(mkey[8 * i +: 8]);
    for (longint unsigned j = 0; j < len; j++) send_byte(8'($urandom_range(0, 255)));
  endtask

  // run time limit
  initial begin
    #1600000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [3:0]  op;
    logic [7:0]  first;
    len_form_e   form;
    logic [63:0] len;
    logic [31:0] mkey;
    int          r;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    rx_byte_i   = 8'h00;
    out_stall_i = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty frames in every length form, each named opcode
    send_frame({1'b1, 3'b000, OP_TEXT}, LEN_SHORT, 64'd0, 1'b0, 32'h0);
    send_frame({1'b1, 3'b000, OP_CLOSE}, LEN_SHORT, 64'd0, 1'b1, 32'hFFFF_FFFF);
    send_frame({1'b1, 3'b000, OP_PING}, LEN_WIDE16, 64'd0, 1'b0, 32'h0);
    send_frame({1'b1, 3'b000, OP_PONG}, LEN_WIDE64, 64'd0, 1'b0, 32'h0);
    // all reserved bits and an unknown opcode, with a short masked payload
    send_frame(8'hFF, LEN_SHORT, 64'd3, 1'b1, 32'hFF00_A55A);

    // random well-formed frames
    while (bytes_sent < 1400) begin
      case ($urandom_range(0, 5))
        0: op = OP_TEXT;
        1: op = OP_CLOSE;
        2: op = OP_PING;
        3: op = OP_PONG;
        4: op = 4'h0;
        default: op = 4'($urandom_range(0, 15));
      endcase
      first = {1'b1, 3'($urandom_range(0, 7)), op};
      r = $urandom_range(0, 99);
      if (r < 70) begin
        form = LEN_SHORT;
        len  = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(0, 125))
                                           : 64'($urandom_range(0, 12));
      end else begin
        form = (r < 85) ? LEN_WIDE16 : LEN_WIDE64;
        len  = ($urandom_range(0, 19) == 0) ? 64'($urandom_range(256, 300))
                                             : 64'($urandom_range(0, 20));
      end
      case ($urandom_range(0, 9))
        0: mkey = 32'h0000_0000;
        1: mkey = 32'hFFFF_FFFF;
        default: mkey = $urandom;
      endcase
      send_frame(first, form, len, 1'($urandom_range(0, 1)), mkey);
    end

    // missing fin, then beats that the halted parser must swallow
    send_byte({1'b0, 3'b000, OP_TEXT});
    send_frame({1'b1, 3'b000, OP_TEXT}, LEN_SHORT, 64'd4, 1'b0, 32'h0);
    in_valid_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/wsfd_pkg.sv
src/wsfd_front.sv
src/wsfd_queue.sv
src/wsfd_back.sv
src/websocket_frame_deframer_core.sv
bench/websocket_frame_deframer_core_test.sv
